// ----- rtl/psc_pkg.sv -----
// Shared types and constants for the PID speed controller channel.
package psc_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int ERR_W      = DATA_WIDTH + 1;
  localparam int DERIV_W    = DATA_WIDTH + 2;
  localparam int ISUM_W     = ERR_W + 1;
  localparam int INTEG_W    = 11;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int DRIVE_W    = 16;
  localparam int FRAC_W     = 8;

  localparam int PROD_P_W   = ERR_W + GAIN_W;
  localparam int PROD_I_W   = INTEG_W + GAIN_W;
  localparam int PROD_D_W   = DERIV_W + GAIN_W;
  localparam int SUM_W      = PROD_D_W + 2;
  localparam int Q_W        = SUM_W - FRAC_W;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [INTEG_W-1:0] ILIM_POS = 11'sd1000;
  localparam logic signed [INTEG_W-1:0] ILIM_NEG = -11'sd1000;

  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 15'd255;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_PROP   = 2'd0,
    REG_GAIN_INTEG  = 2'd1,
    REG_GAIN_DERIV  = 2'd2,
    REG_DRIVE_LIMIT = 2'd3
  } psc_reg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERIV_W-1:0] deriv;
  } psc_terms_t;

endpackage

// ----- rtl/pid_speed_controller.sv -----
// Top level of one PID speed controller channel.
//
// Input stream: one beat per control tick carrying setpoint and measured.
// Output stream: one beat per tick carrying the clamped drive value.
// Gains (signed Q8.8), drive limit: cfg write port, one register per write;
// the user writes only while no beat is in flight; not enforced by the block.
// Pipeline: the input beat passes the term, product and result registers
// before out_tvalid rises. Throughput: one beat per cycle while out_tready is
// high; the gain multipliers and the sum/clamp each take one pipeline stage.
// Integral and previous error update when an input beat is accepted.
// Reset: gains clear to zero, drive limit becomes 255, integral and
// previous error clear, pipeline empties.
// A stalled receiver holds the output beat; each stage keeps its data and
// in_tready falls once every stage is full, so no beat is lost.
module pid_speed_controller import psc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [31:0]             in_tdata,   // setpoint [15:0], measured [31:16]
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [15:0]             out_tdata,  // drive [15:0]
  input  logic                    cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  logic signed [GAIN_W-1:0]  gain_prop_r, gain_integ_r, gain_deriv_r;
  logic        [LIMIT_W-1:0] drive_limit_r;
  logic                      terms_vld, terms_rdy;
  psc_terms_t                terms;
  logic signed [DRIVE_W-1:0] drive;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r   <= '0;
      gain_integ_r  <= '0;
      gain_deriv_r  <= '0;
      drive_limit_r <= DRIVE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (psc_reg_t'(cfg_addr))
        REG_GAIN_PROP:   gain_prop_r   <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_INTEG:  gain_integ_r  <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_DERIV:  gain_deriv_r  <= cfg_wdata[GAIN_W-1:0];
        REG_DRIVE_LIMIT: drive_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  psc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .setpoint  (in_tdata[15:0]),
    .measured  (in_tdata[31:16]),
    .terms_vld (terms_vld),
    .terms_rdy (terms_rdy),
    .terms     (terms)
  );

  psc_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .terms_vld   (terms_vld),
    .terms_rdy   (terms_rdy),
    .terms       (terms),
    .gain_prop   (gain_prop_r),
    .gain_integ  (gain_integ_r),
    .gain_deriv  (gain_deriv_r),
    .drive_limit (drive_limit_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .drive       (drive)
  );

  assign out_tdata = drive;

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    terms_vld |-> (terms.integ <= ILIM_POS) && (terms.integ >= ILIM_NEG))
    else $error("integral term outside its limit");

  a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (DRIVE_W'($signed({1'b0, drive_limit_r})) >= drive) &&
                   (-DRIVE_W'($signed({1'b0, drive_limit_r})) <= drive))
    else $error("drive beyond drive limit");

  a_terms_hold: assert property (@(posedge clk) disable iff (!rst_n)
    terms_vld && !terms_rdy |=> terms_vld && $stable(terms))
    else $error("term stage changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !terms_vld)
    else $error("pipeline not empty after reset");

endmodule

// ----- rtl/psc_front.sv -----
// Error, clamped integral and derivative stage; holds the loop state.
module psc_front import psc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] setpoint,
  input  logic signed [DATA_WIDTH-1:0] measured,
  output logic                         terms_vld,
  input  logic                         terms_rdy,
  output psc_terms_t                   terms
);

  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   prev_err_r;
  logic                      vld_r, vld_nxt;
  psc_terms_t                terms_r, terms_nxt;

  logic signed [ERR_W-1:0]   err;
  logic signed [ISUM_W-1:0]  isum;
  logic                      load;

  assign in_ready = !vld_r || terms_rdy;
  assign load     = in_valid && in_ready;

  always_comb begin
    err  = ERR_W'(setpoint) - ERR_W'(measured);
    isum = ISUM_W'(integ_r) + ISUM_W'(err);
    if (isum > ISUM_W'(ILIM_POS)) begin
      integ_nxt = ILIM_POS;
    end else if (isum < ISUM_W'(ILIM_NEG)) begin
      integ_nxt = ILIM_NEG;
    end else begin
      integ_nxt = isum[INTEG_W-1:0];
    end
    terms_nxt.err   = err;
    terms_nxt.integ = integ_nxt;
    terms_nxt.deriv = DERIV_W'(err) - DERIV_W'(prev_err_r);
    vld_nxt = load ? 1'b1 : (terms_rdy ? 1'b0 : vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      integ_r    <= '0;
      prev_err_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (load) begin
        integ_r    <= integ_nxt;
        prev_err_r <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms_vld = vld_r;
  assign terms     = terms_r;

endmodule

// ----- rtl/psc_mac.sv -----
// Gain products, sum, truncation toward zero and drive clamp.
module psc_mac import psc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       terms_vld,
  output logic                       terms_rdy,
  input  psc_terms_t                 terms,
  input  logic signed [GAIN_W-1:0]   gain_prop,
  input  logic signed [GAIN_W-1:0]   gain_integ,
  input  logic signed [GAIN_W-1:0]   gain_deriv,
  input  logic        [LIMIT_W-1:0]  drive_limit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DRIVE_W-1:0]  drive
);

  logic signed [PROD_P_W-1:0] prod_p_r;
  logic signed [PROD_I_W-1:0] prod_i_r;
  logic signed [PROD_D_W-1:0] prod_d_r;
  logic                       p_vld_r, p_vld_nxt;
  logic                       o_vld_r, o_vld_nxt;
  logic signed [DRIVE_W-1:0]  drive_r, drive_nxt;
  logic                       rdy_b, load_a, load_b;

  logic signed [SUM_W-1:0]    sum, adj;
  logic signed [Q_W-1:0]      q, lim_pos, lim_neg;

  assign rdy_b     = !o_vld_r || out_ready;
  assign terms_rdy = !p_vld_r || rdy_b;
  assign load_a    = terms_vld && terms_rdy;
  assign load_b    = p_vld_r && rdy_b;

  always_comb begin
    sum = SUM_W'(prod_p_r) + SUM_W'(prod_i_r) + SUM_W'(prod_d_r);
    adj = sum + (sum[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0));
    q   = adj[SUM_W-1:FRAC_W];
    lim_pos = Q_W'($signed({1'b0, drive_limit}));
    lim_neg = -lim_pos;
    if (q > lim_pos) begin
      drive_nxt = lim_pos[DRIVE_W-1:0];
    end else if (q < lim_neg) begin
      drive_nxt = lim_neg[DRIVE_W-1:0];
    end else begin
      drive_nxt = q[DRIVE_W-1:0];
    end
    p_vld_nxt = load_a ? 1'b1 : (rdy_b ? 1'b0 : p_vld_r);
    o_vld_nxt = load_b ? 1'b1 : (out_ready ? 1'b0 : o_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      p_vld_r <= p_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      prod_p_r <= PROD_P_W'(terms.err)   * PROD_P_W'(gain_prop);
      prod_i_r <= PROD_I_W'(terms.integ) * PROD_I_W'(gain_integ);
      prod_d_r <= PROD_D_W'(terms.deriv) * PROD_D_W'(gain_deriv);
    end
    if (load_b) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid = o_vld_r;
  assign drive     = drive_r;

endmodule

// ----- sim/tb_pid_speed_controller.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for one PID speed controller channel, with a drive-value predictor.
module tb_pid_speed_controller;
  import psc_pkg::*;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata   = '0;  // setpoint [15:0], measured [31:16]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;        // drive [15:0]
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // predictor copy of registers and loop state
  logic signed [GAIN_W-1:0]  kp        = '0;
  logic signed [GAIN_W-1:0]  ki        = '0;
  logic signed [GAIN_W-1:0]  kd        = '0;
  logic [LIMIT_W-1:0]        drive_lim = DRIVE_LIMIT_RST;
  logic signed [INTEG_W-1:0] integ_acc = '0;
  logic signed [ERR_W-1:0]   last_err  = '0;

  logic signed [DRIVE_W-1:0] expected_drive[$];
  int n_err     = 0;
  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;

  pid_speed_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [DRIVE_W-1:0] predict_drive(
    input logic signed [DATA_WIDTH-1:0] sp,
    input logic signed [DATA_WIDTH-1:0] ms
  );
    longint e;
    longint d;
    longint i_next;
    longint s;
    longint q;
    longint lim_l;
    e      = longint'(sp) - longint'(ms);
    i_next = longint'(integ_acc) + e;
    if (i_next > longint'(ILIM_POS)) i_next = longint'(ILIM_POS);
    if (i_next < longint'(ILIM_NEG)) i_next = longint'(ILIM_NEG);
    d = e - longint'(last_err);
    s = e * longint'(kp) + d * longint'(kd) + i_next * longint'(ki);
    q = s / 256;  // truncates toward zero
    lim_l = drive_lim;
    if (q > lim_l) q = lim_l;
    if (q < -lim_l) q = -lim_l;
    integ_acc = i_next[INTEG_W-1:0];
    last_err  = e[ERR_W-1:0];
    return q[DRIVE_W-1:0];
  endfunction

  task automatic write_reg(input psc_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_GAIN_PROP:   kp = val;
      REG_GAIN_INTEG:  ki = val;
      REG_GAIN_DERIV:  kd = val;
      REG_DRIVE_LIMIT: drive_lim = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] gp, input logic [15:0] gi,
                           input logic [15:0] gd, input logic [15:0] lim);
    write_reg(REG_GAIN_PROP, gp);
    write_reg(REG_GAIN_INTEG, gi);
    write_reg(REG_GAIN_DERIV, gd);
    write_reg(REG_DRIVE_LIMIT, lim);
  endtask

  task automatic send_tick(input logic signed [DATA_WIDTH-1:0] sp,
                           input logic signed [DATA_WIDTH-1:0] ms);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ms, sp};
    do @(posedge clk); while (!in_tready);
    expected_drive.push_back(predict_drive(sp, ms));
  endtask

  // drain the pipe before touching registers
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_after_reset();
    send_tick(16'sh7FFF, 16'sh8000);
    send_tick(16'sh8000, 16'sh7FFF);
    send_tick(16'sd0, 16'sd0);
    send_tick(-16'sd1, -16'sd1);
    settle();
    // drive limit still at its reset value
    write_reg(REG_GAIN_PROP, 16'sd256);
    send_tick(16'sd1000, 16'sd0);
    send_tick(-16'sd1000, 16'sd0);
  endtask

  task automatic test_extremes();
    settle();
    write_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_tick(16'sh7FFF, 16'sh8000);
    send_tick(16'sh8000, 16'sh7FFF);
    send_tick(16'sh8000, 16'sh7FFF);
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sh8000, 16'sh8000);
    settle();
    // negative proportional and derivative gains
    write_all(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_tick(16'sh7FFF, 16'sh8000);
    send_tick(16'sh8000, 16'sh7FFF);
    send_tick(16'sd12345, -16'sd54);
  endtask

  task automatic test_zero_limit();
    settle();
    write_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
    repeat (4) send_tick(16'($urandom), 16'($urandom));
  endtask

  task automatic test_integral_clamp();
    settle();
    write_all(16'h0000, 16'sd256, 16'h0000, 16'h7FFF);
    send_tick(16'sd0, 16'sh7FFF);
    repeat (4) send_tick(16'sd600, 16'sd0);
    repeat (3) send_tick(16'sd0, 16'sd900);
  endtask

  task automatic test_random_phases();
    int base;
    int delta;
    logic [15:0] gp;
    logic [15:0] gi;
    logic [15:0] gd;
    logic [15:0] lim;
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      case (ph)
        0: begin
          gp = 16'h7FFF; gi = 16'h7FFF; gd = 16'h7FFF; lim = 16'h7FFF;
        end
        1: begin
          gp = 16'h8000; gi = 16'h8000; gd = 16'h8000; lim = 16'd1;
        end
        default: begin
          if ($urandom_range(0, 2) == 0) begin
            gp = 16'($urandom); gi = 16'($urandom); gd = 16'($urandom);
          end else begin
            gp = 16'(int'($urandom_range(0, 2048)) - 1024);
            gi = 16'(int'($urandom_range(0, 2048)) - 1024);
            gd = 16'(int'($urandom_range(0, 2048)) - 1024);
          end
          lim = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        end
      endcase
      write_all(gp, gi, gd, lim);
      in_burst = (ph % 4 == 3);
      base = int'($urandom_range(0, 60000)) - 30000;
      repeat (128) begin
        if ($urandom_range(0, 31) == 0) base = int'($urandom_range(0, 60000)) - 30000;
        if ($urandom_range(0, 4) == 0) begin
          send_tick(16'($urandom), 16'($urandom));
        end else begin
          // tracking: measured stays within 400 of the setpoint
          delta = int'($urandom_range(0, 800)) - 400;
          send_tick(16'(base), 16'(base + delta));
        end
      end
    end
    in_burst = 1'b0;
  endtask

  initial begin : drive_check
    int stall;
    logic signed [DRIVE_W-1:0] exp_d;
    @(posedge clk iff rst_n);
    forever begin
      if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (expected_drive.size() == 0) begin
        n_err++;
        $error("drive: expected none, got %0d", $signed(out_tdata));
      end else begin
        exp_d = expected_drive.pop_front();
        if (out_tdata !== exp_d) begin
          n_err++;
          $error("drive: expected %0d, got %0d", exp_d, $signed(out_tdata));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_extremes();
    test_zero_limit();
    test_integral_clamp();
    test_random_phases();
    settle();
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/psc_pkg.sv
rtl/psc_front.sv
rtl/psc_mac.sv
rtl/pid_speed_controller.sv
sim/tb_pid_speed_controller.sv
